// ===== hdl/hamt_pkg.sv =====
// ----------------------------------------------------------------------------
// hamt_pkg
// Shared constants and types for the hashed address map table.
// ----------------------------------------------------------------------------
`default_nettype none

package hamt_pkg;

	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned HASH_STEPS = 7;

	localparam logic [ADDR_W-1:0] SEED_RESET = 32'd7963;
	localparam logic [ADDR_W-1:0] JHASH_INIT = 32'hdeadbeef;

	// request codes
	localparam logic [1:0] FN_LOOKUP = 2'd0;
	localparam logic [1:0] FN_INSERT = 2'd1;
	localparam logic [1:0] FN_DELETE = 2'd2;

	// response codes
	localparam logic [1:0] RS_OK   = 2'd0;
	localparam logic [1:0] RS_MISS = 2'd1;
	localparam logic [1:0] RS_FULL = 2'd2;

	typedef logic [1:0]        func_t;
	typedef logic [1:0]        status_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic  vld;
		addr_t key;
		addr_t val;
	} entry_t;

endpackage

`default_nettype wire

// ===== hdl/hamt_if.sv =====
// ----------------------------------------------------------------------------
// hamt_if
// Valid/ready channels of the hashed address map table.
// ----------------------------------------------------------------------------
`default_nettype none

interface hamt_req_if import hamt_pkg::*; ();
	logic  valid;
	logic  ready;
	func_t func;
	addr_t key_addr;
	addr_t value_addr;

	modport source (output valid, func, key_addr, value_addr, input ready);
	modport sink   (input valid, func, key_addr, value_addr, output ready);
endinterface

interface hamt_rsp_if import hamt_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	addr_t   found_value;

	modport source (output valid, status, found_value, input ready);
	modport sink   (input valid, status, found_value, output ready);
endinterface

interface hamt_cfg_if import hamt_pkg::*; ();
	logic  valid;
	logic  ready;
	addr_t hash_seed;

	modport source (output valid, hash_seed, input ready);
	modport sink   (input valid, hash_seed, output ready);
endinterface

`default_nettype wire

// ===== hdl/hashed_address_map_table_unit.sv =====
// ----------------------------------------------------------------------------
// hashed_address_map_table_unit
// Bucketed hash map of 32-bit keys to 32-bit values, one row per bucket.
// ----------------------------------------------------------------------------
// Steps from request beat to response valid: 7 hash mix steps on one shared
//   xor/rotate/subtract unit, a reciprocal-multiply remainder when BUCKETS is
//   not a power of two, 1 row read, 1 compare and write back, which waits out a
//   stalled response. A new request is taken only after the last one's write back.
// Reset: a clearing pass over every row zeroes the valid bits; no request
//   is taken meanwhile. Config writes are taken at any time.
`default_nettype none

module hashed_address_map_table_unit import hamt_pkg::*; #(
	parameter int unsigned BUCKETS = 256,
	parameter int unsigned WAYS    = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	hamt_cfg_if.sink   cfg,
	hamt_req_if.sink   req,
	hamt_rsp_if.source rsp
);

	localparam int unsigned BW     = $clog2(BUCKETS);
	localparam int unsigned WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam bit          IS_POW2 = ((1 << BW) == BUCKETS);
	localparam addr_t       RECIP  = addr_t'((64'd1 << ADDR_W) / BUCKETS);

	typedef entry_t [WAYS-1:0] row_t;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_HASH  = 6'b000100,
		ST_MOD   = 6'b001000,
		ST_READ  = 6'b010000,
		ST_EVAL  = 6'b100000
	} state_t;

	state_t      state_q;
	logic [2:0]  step_q;
	logic        bit_q;
	logic [BW-1:0] clr_q;
	addr_t       seed_q;
	logic        rsp_valid_q;
	status_t     rsp_status_q;
	addr_t       rsp_found_q;

	addr_t   ha_q, hb_q, hc_q;
	addr_t   quo_q;
	logic [BW:0] rem_q;
	func_t   func_q;
	addr_t   key_q;
	addr_t   val_q;

	row_t    mem [BUCKETS];
	row_t    row_q;

	logic    req_fire;
	logic    eval_fire;
	addr_t   iv;

	// shared mix unit
	addr_t       mx_src, mx_dst, mx_rot, mx_res;
	logic [2:0]  mx_tgt;

	logic [2*ADDR_W-1:0] recip_prod;
	addr_t               rem_calc;
	logic [BW:0]         rem_sub;
	logic [BW-1:0]       bkt;

	logic          hit_ok, hole_ok;
	logic [WW-1:0] hit_w, hole_w;
	row_t          new_row;
	status_t       ev_status;
	addr_t         ev_found;

	logic          mem_we;
	logic [BW-1:0] mem_wa;
	row_t          mem_wd;

	assign cfg.ready   = 1'b1;
	assign req.ready   = (state_q == ST_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = rsp_status_q;
	assign rsp.found_value = rsp_found_q;

	assign req_fire  = req.valid && (state_q == ST_IDLE);
	assign eval_fire = (state_q == ST_EVAL) && (!rsp_valid_q || rsp.ready);
	assign iv        = seed_q + JHASH_INIT + 32'd4;

	always_comb begin
		mx_src = '0;
		mx_dst = '0;
		mx_rot = '0;
		mx_tgt = 3'b000;
		unique case (step_q)
			3'd0: begin mx_src = hb_q; mx_dst = hc_q; mx_rot = {hb_q[17:0], hb_q[31:18]}; mx_tgt = 3'b100; end
			3'd1: begin mx_src = hc_q; mx_dst = ha_q; mx_rot = {hc_q[20:0], hc_q[31:21]}; mx_tgt = 3'b001; end
			3'd2: begin mx_src = ha_q; mx_dst = hb_q; mx_rot = {ha_q[6:0],  ha_q[31:7]};  mx_tgt = 3'b010; end
			3'd3: begin mx_src = hb_q; mx_dst = hc_q; mx_rot = {hb_q[15:0], hb_q[31:16]}; mx_tgt = 3'b100; end
			3'd4: begin mx_src = hc_q; mx_dst = ha_q; mx_rot = {hc_q[27:0], hc_q[31:28]}; mx_tgt = 3'b001; end
			3'd5: begin mx_src = ha_q; mx_dst = hb_q; mx_rot = {ha_q[17:0], ha_q[31:18]}; mx_tgt = 3'b010; end
			3'd6: begin mx_src = hb_q; mx_dst = hc_q; mx_rot = {hb_q[7:0],  hb_q[31:8]};  mx_tgt = 3'b100; end
			default: begin end
		endcase
		mx_res = (mx_dst ^ mx_src) - mx_rot;
	end

	// remainder by BUCKETS: quotient estimate is low by at most one
	assign recip_prod = (2*ADDR_W)'(hc_q) * (2*ADDR_W)'(RECIP);
	assign rem_calc   = hc_q - addr_t'(quo_q * addr_t'(BUCKETS));
	assign rem_sub    = rem_q - (BW+1)'(BUCKETS);
	assign bkt        = IS_POW2 ? hc_q[BW-1:0] :
		((rem_q >= (BW+1)'(BUCKETS)) ? rem_sub[BW-1:0] : rem_q[BW-1:0]);

	always_comb begin
		hit_ok  = 1'b0;
		hole_ok = 1'b0;
		hit_w   = '0;
		hole_w  = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (row_q[w].vld) begin
				if (!hit_ok && row_q[w].key == key_q) begin
					hit_ok = 1'b1;
					hit_w  = WW'(w);
				end
			end else if (!hole_ok) begin
				hole_ok = 1'b1;
				hole_w  = WW'(w);
			end
		end
	end

	always_comb begin
		new_row   = row_q;
		ev_status = RS_MISS;
		ev_found  = '0;
		unique case (func_q)
			FN_LOOKUP: begin
				if (hit_ok) begin
					ev_status = RS_OK;
					ev_found  = row_q[hit_w].val;
				end
			end
			FN_INSERT: begin
				if (hit_ok) begin
					new_row[hit_w].val = val_q;
					ev_status = RS_OK;
				end else if (hole_ok) begin
					new_row[hole_w] = '{vld: 1'b1, key: key_q, val: val_q};
					ev_status = RS_OK;
				end else begin
					ev_status = RS_FULL;
				end
			end
			FN_DELETE: begin
				if (hit_ok && row_q[hit_w].val == val_q) begin
					new_row[hit_w].vld = 1'b0;
					ev_status = RS_OK;
				end
			end
			default: begin end
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = bkt;
		mem_wd = new_row;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (eval_fire) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (state_q == ST_READ) begin
			row_q <= mem[bkt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			step_q      <= '0;
			bit_q       <= '0;
			clr_q       <= '0;
			seed_q      <= SEED_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				seed_q <= cfg.hash_seed;
			end
			if (eval_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					step_q <= '0;
					if (req_fire) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					step_q <= step_q + 1'b1;
					bit_q  <= 1'b0;
					if (step_q == 3'(HASH_STEPS - 1)) begin
						state_q <= IS_POW2 ? ST_READ : ST_MOD;
					end
				end
				ST_MOD: begin
					bit_q <= 1'b1;
					if (bit_q == 1'b1) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (eval_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			func_q <= req.func;
			key_q  <= req.key_addr;
			val_q  <= req.value_addr;
			ha_q   <= req.key_addr + iv;
			hb_q   <= iv;
			hc_q   <= iv;
			rem_q  <= '0;
		end else if (state_q == ST_HASH) begin
			if (mx_tgt[0]) ha_q <= mx_res;
			if (mx_tgt[1]) hb_q <= mx_res;
			if (mx_tgt[2]) hc_q <= mx_res;
		end else if (state_q == ST_MOD) begin
			if (bit_q == 1'b0) begin
				quo_q <= recip_prod[2*ADDR_W-1:ADDR_W];
			end else begin
				rem_q <= rem_calc[BW:0];
			end
		end
		if (eval_fire) begin
			rsp_status_q <= ev_status;
			rsp_found_q  <= ev_found;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/hamt_checker.sv =====
// ----------------------------------------------------------------------------
// hamt_checker
// Port-level checks of the hashed address map table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hamt_checker import hamt_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input wire        req_valid,
	input wire        req_ready,
	input wire        rsp_valid,
	input wire        rsp_ready,
	input wire [1:0]  rsp_status,
	input wire [31:0] rsp_found_value
);

	// busy while a request is in flight
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready stayed high after a request beat");

	a_no_quick_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("response rose one cycle after a request beat");

	a_value_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found_value != '0 |-> rsp_status == RS_OK)
		else $error("nonzero value with a failing status");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_found_value))
		else $error("stalled response beat changed");

endmodule

bind hashed_address_map_table_unit hamt_checker u_hamt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_found_value (rsp.found_value)
);

`default_nettype wire

// ===== tb/hashed_address_map_table_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hashed_address_map_table_unit_checker
// Watches the seed, request and response channels of the address map table.
// Keeps its own copy of the bucket rows and the seed, predicts one response
// per request beat and compares each response beat with the oldest one due.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_address_map_table_unit_checker import hamt_pkg::*; #(
	parameter int unsigned BUCKETS = 256,
	parameter int unsigned WAYS    = 4
) (
	input  wire  clk,
	input  wire  arst_n,
	hamt_cfg_if  cfg,
	hamt_req_if  req,
	hamt_rsp_if  rsp,
	output int   fail_count,
	output int   pending,
	output int   hit_count,
	output int   full_count,
	output int   freed_count
);

	localparam int unsigned ENTRIES = BUCKETS * WAYS;

	typedef struct {
		status_t status;
		addr_t   value;
	} reply_t;

	reply_t replies_due [$];
	addr_t  seed;
	addr_t  key_mem   [ENTRIES];
	addr_t  value_mem [ENTRIES];
	bit     way_used  [ENTRIES];

	function automatic addr_t rol32(addr_t x, int unsigned r);
		return (x << r) | (x >> (32 - r));
	endfunction

	// final mix of a one-word keyed hash, reduced to a bucket
	function automatic int unsigned bucket_index(addr_t seed_v, addr_t key);
		addr_t iv, a, b, c;
		iv = seed_v + JHASH_INIT + 32'd4;
		a = key + iv;
		b = iv;
		c = iv;
		c ^= b; c -= rol32(b, 14);
		a ^= c; a -= rol32(c, 11);
		b ^= a; b -= rol32(a, 25);
		c ^= b; c -= rol32(b, 16);
		a ^= c; a -= rol32(c, 4);
		b ^= a; b -= rol32(a, 14);
		c ^= b; c -= rol32(b, 24);
		return c % BUCKETS;
	endfunction

	function automatic reply_t serve_request(func_t f, addr_t key, addr_t v);
		int unsigned base;
		int          hit, hole, w;
		reply_t      r;
		base = bucket_index(seed, key) * WAYS;
		hit = -1;
		hole = -1;
		r.status = RS_MISS;
		r.value = '0;
		for (w = 0; w < WAYS; w++) begin
			if (way_used[base + w]) begin
				if (hit < 0 && key_mem[base + w] == key)
					hit = w;
			end else if (hole < 0) begin
				hole = w;
			end
		end
		case (f)
			FN_LOOKUP: begin
				if (hit >= 0) begin
					r.status = RS_OK;
					r.value = value_mem[base + hit];
					hit_count++;
				end
			end
			FN_INSERT: begin
				if (hit >= 0) begin
					value_mem[base + hit] = v;
					r.status = RS_OK;
				end else if (hole >= 0) begin
					key_mem[base + hole] = key;
					value_mem[base + hole] = v;
					way_used[base + hole] = 1'b1;
					r.status = RS_OK;
				end else begin
					r.status = RS_FULL;
					full_count++;
				end
			end
			FN_DELETE: begin
				if (hit >= 0 && value_mem[base + hit] == v) begin
					way_used[base + hit] = 1'b0;
					r.status = RS_OK;
					freed_count++;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t due;
		if (!arst_n) begin
			seed = SEED_RESET;
			foreach (way_used[i])
				way_used[i] = 1'b0;
			replies_due.delete();
			fail_count = 0;
			hit_count = 0;
			full_count = 0;
			freed_count = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (replies_due.size() == 0) begin
					fail_count++;
					$display("%0t unexpected response beat: status %0d value %h",
						$time, rsp.status, rsp.found_value);
				end else begin
					due = replies_due.pop_front();
					if (rsp.status !== due.status) begin
						fail_count++;
						$display("%0t status mismatch: expected %0d, got %0d",
							$time, due.status, rsp.status);
					end
					if (rsp.found_value !== due.value) begin
						fail_count++;
						$display("%0t found_value mismatch: expected %h, got %h",
							$time, due.value, rsp.found_value);
					end
				end
			end
			if (cfg.valid && cfg.ready)
				seed = cfg.hash_seed;
			if (req.valid && req.ready)
				replies_due.push_back(serve_request(req.func, req.key_addr, req.value_addr));
		end
		pending = replies_due.size();
	end

endmodule

`default_nettype wire

// ===== tb/hashed_address_map_table_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hashed_address_map_table_unit_tb
// Drives lookups, inserts and exact-pair deletes into the address map table
// under several hash seeds, steering most keys into a few crowded buckets so
// that replacement, full buckets and freed ways all occur. Both sides idle in
// random bursts; one long response stall backs the table up. The checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_address_map_table_unit_tb import hamt_pkg::*;;

	localparam int unsigned BUCKETS         = 256;
	localparam int unsigned WAYS            = 4;
	localparam func_t       FN_UNUSED       = 2'd3;
	localparam int          CLK_HALF        = 10;
	localparam int          RESET_CYCLES    = 10;
	localparam int          WATCHDOG_LIMIT  = 2000;
	localparam int          LONG_HOLD       = 300;
	localparam int          TAIL_CYCLES     = 30;
	localparam int          HOT_BUCKETS     = 6;
	localparam int          KEYS_PER_BUCKET = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hamt_cfg_if cfg ();
	hamt_req_if req ();
	hamt_rsp_if rsp ();

	int fail_count, pending, hit_count, full_count, freed_count;
	int idle_cycles = 0;
	int requests_sent = 0;
	int seeds_used = 1;
	bit calm = 1'b0;
	bit long_hold = 1'b0;

	addr_t seed_now;
	addr_t hot_keys [$];
	addr_t last_value [addr_t];

	always #(CLK_HALF) clk = ~clk;

	hashed_address_map_table_unit #(.BUCKETS(BUCKETS), .WAYS(WAYS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

	hashed_address_map_table_unit_checker #(.BUCKETS(BUCKETS), .WAYS(WAYS)) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.req         (req),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.pending     (pending),
		.hit_count   (hit_count),
		.full_count  (full_count),
		.freed_count (freed_count)
	);

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : rsp_drain
		int n;
		rsp.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				rsp.ready <= 1'b0;
				for (n = 0; n < LONG_HOLD; n++)
					@(negedge clk);
				long_hold = 1'b0;
				rsp.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the beat
	task automatic send(func_t f, addr_t k, addr_t v);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.func <= f;
		req.key_addr <= k;
		req.value_addr <= v;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
		if (f == FN_INSERT)
			last_value[k] = v;
		requests_sent++;
	endtask

	task automatic find_collider(int unsigned bucket, output addr_t k);
		k = $urandom;
		while (chk.bucket_index(seed_now, k) != bucket)
			k = $urandom;
	endtask

	task automatic refresh_hot_keys();
		int unsigned b;
		addr_t k;
		hot_keys.delete();
		repeat (HOT_BUCKETS) begin
			b = $urandom_range(0, BUCKETS - 1);
			repeat (KEYS_PER_BUCKET) begin
				find_collider(b, k);
				hot_keys.push_back(k);
			end
		end
	endtask

	task automatic write_seed(addr_t s);
		req.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		cfg.valid <= 1'b1;
		cfg.hash_seed <= s;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
		seed_now = s;
		seeds_used++;
		refresh_hot_keys();
	endtask

	task automatic random_item();
		int unsigned roll;
		func_t f;
		addr_t k, v;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			k = hot_keys[$urandom_range(0, hot_keys.size() - 1)];
		else if (roll < 80)
			k = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
		else
			k = $urandom;
		roll = $urandom_range(0, 99);
		f = (roll < 35) ? FN_LOOKUP : (roll < 70) ? FN_INSERT :
			(roll < 97) ? FN_DELETE : FN_UNUSED;
		roll = $urandom_range(0, 19);
		v = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hffff_ffff : addr_t'($urandom);
		if (f == FN_DELETE && last_value.exists(k) && $urandom_range(0, 3) != 0)
			v = last_value[k];
		send(f, k, v);
	endtask

	task automatic directed_items();
		addr_t crowd [5];
		int unsigned b;
		int i;
		send(FN_LOOKUP, 32'h0, 32'h0);
		send(FN_INSERT, 32'h0, 32'hffff_ffff);
		send(FN_INSERT, 32'hffff_ffff, 32'h0);
		send(FN_LOOKUP, 32'h0, 32'h0);
		send(FN_LOOKUP, 32'hffff_ffff, 32'hffff_ffff);
		send(FN_INSERT, 32'h0, 32'h1234_5678);
		send(FN_LOOKUP, 32'h0, 32'h0);
		send(FN_DELETE, 32'h0, 32'hffff_ffff);
		send(FN_DELETE, 32'h0, 32'h1234_5678);
		send(FN_LOOKUP, 32'h0, 32'h0);
		send(FN_DELETE, 32'h0, 32'h1234_5678);
		send(FN_UNUSED, 32'hffff_ffff, 32'h0);
		// five keys of one bucket: the fifth finds it full
		crowd[0] = 32'h8000_0001;
		b = chk.bucket_index(seed_now, crowd[0]);
		for (i = 1; i < 5; i++)
			find_collider(b, crowd[i]);
		for (i = 0; i < 5; i++)
			send(FN_INSERT, crowd[i], 32'ha5a5_0000 | i);
		send(FN_LOOKUP, crowd[4], 32'h0);
		send(FN_INSERT, crowd[3], 32'h5a5a_5a5a);
		send(FN_DELETE, crowd[1], 32'ha5a5_0001);
		send(FN_INSERT, crowd[4], 32'hffff_ffff);
		send(FN_LOOKUP, crowd[4], 32'h0);
		send(FN_LOOKUP, crowd[3], 32'h0);
	endtask

	initial begin
		req.valid = 1'b0;
		req.func = FN_LOOKUP;
		req.key_addr = '0;
		req.value_addr = '0;
		cfg.valid = 1'b0;
		cfg.hash_seed = '0;
		seed_now = SEED_RESET;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		refresh_hot_keys();

		directed_items();
		repeat (100) random_item();

		write_seed(32'h0);
		repeat (40) random_item();
		long_hold = 1'b1;
		repeat (80) random_item();

		write_seed(32'hffff_ffff);
		repeat (120) random_item();

		write_seed($urandom);
		repeat (80) random_item();
		calm = 1'b1;
		repeat (60) random_item();

		req.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d requests under %0d hash seeds, incl. a %0d-cycle response stall",
			requests_sent, seeds_used, LONG_HOLD);
		$display("%0d lookup hits, %0d inserts into full buckets, %0d exact-pair deletes",
			hit_count, full_count, freed_count);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
